[rtl/fpdf_pkg.sv]
// ----------------------------------------------------------------------------
// fpdf_pkg: fixed-point decimal formatter shared definitions
// Widths, character codes, item classes and the structs passed between the
// front, converter and emitter.
// ----------------------------------------------------------------------------
package fpdf_pkg;

  localparam int AMOUNT_IN_W   = 64;
  localparam int PLACES_W      = 5;
  localparam int CHAR_W        = 8;

  localparam int AMOUNT_BITS   = 64;
  localparam int MAX_DECIMALS  = 19;

  localparam int NUM_DIGITS    = 20;
  localparam int DIGIT_W       = 4;
  localparam int DIGIT_IDX_W   = $clog2(NUM_DIGITS);

  // binary bits consumed by the converter per cycle
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = (AMOUNT_BITS + BITS_PER_STEP - 1) / BITS_PER_STEP;
  localparam int CONV_W        = CONV_STEPS * BITS_PER_STEP;
  localparam int STEP_CNT_W    = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;

  localparam int QUEUE_DEPTH   = 2;
  localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
  localparam int QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_DOT  = 8'h2E;
  localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_ZERO,
    KIND_ERR
  } kind_t;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  typedef struct packed {
    logic [AMOUNT_BITS-1:0] amount;
    logic [PLACES_W-1:0]    places;
    kind_t                  kind;
  } job_t;

  typedef struct packed {
    digits_t             digits;
    logic [PLACES_W-1:0] places;
    kind_t               kind;
  } conv_res_t;

endpackage

[rtl/fpdf_if.sv]
// ----------------------------------------------------------------------------
// fpdf_in_if / fpdf_out_if: formatter channels
// Valid/ready channels for amounts in and characters out.
// ----------------------------------------------------------------------------
interface fpdf_in_if;
  logic                             valid;
  logic                             ready;
  logic [fpdf_pkg::AMOUNT_IN_W-1:0] amount;
  logic [fpdf_pkg::PLACES_W-1:0]    decimal_places;

  modport source (output valid, output amount, output decimal_places, input ready);
  modport sink   (input valid, input amount, input decimal_places, output ready);
endinterface

interface fpdf_out_if;
  logic                        valid;
  logic                        ready;
  logic [fpdf_pkg::CHAR_W-1:0] character;
  logic                        last;
  logic                        error;

  modport source (output valid, output character, output last, output error, input ready);
  modport sink   (input valid, input character, input last, input error, output ready);
endinterface

[rtl/fpdf_front.sv]
// ----------------------------------------------------------------------------
// fpdf_front: accept and classify
// Masks the amount, sorts each word into number, zero or error, and queues it
// for the converter.
// ----------------------------------------------------------------------------
module fpdf_front (
  input  logic            clk,
  input  logic            rst_n,
  fpdf_in_if.sink         in_ch,
  output logic            job_valid,
  output fpdf_pkg::job_t  job,
  input  logic            job_pop
);
  import fpdf_pkg::*;

  job_t                   mem_r [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QUEUE_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QUEUE_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                   push;
  logic                   pop;
  logic [AMOUNT_BITS-1:0] amt;
  job_t                   new_job;

  assign in_ch.ready = (cnt_r != QUEUE_CNT_W'(QUEUE_DEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign job_valid   = (cnt_r != '0);
  assign pop         = job_pop && job_valid;
  assign job         = mem_r[rd_ptr_r];

  always_comb begin
    amt            = in_ch.amount[AMOUNT_BITS-1:0];
    new_job.amount = amt;
    new_job.places = in_ch.decimal_places;
    // zero wins over a bad place count
    if (amt == '0) begin
      new_job.kind = KIND_ZERO;
    end else if (in_ch.decimal_places > PLACES_W'(MAX_DECIMALS)) begin
      new_job.kind = KIND_ERR;
    end else begin
      new_job.kind = KIND_NUM;
    end
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_job;
    end
  end

endmodule

[rtl/fpdf_conv.sv]
// ----------------------------------------------------------------------------
// fpdf_conv: binary to BCD converter
// Shift-and-add-3 conversion, several bits per cycle, holding the digits
// until the emitter takes them.
// ----------------------------------------------------------------------------
module fpdf_conv (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                job_valid,
  input  fpdf_pkg::job_t      job,
  output logic                job_pop,
  output logic                res_valid,
  output fpdf_pkg::conv_res_t res,
  input  logic                res_take
);
  import fpdf_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_t;

  state_t                state_r;
  logic [CONV_W-1:0]     bin_r;
  digits_t               bcd_r;
  logic [PLACES_W-1:0]   places_r;
  kind_t                 kind_r;
  logic [STEP_CNT_W-1:0] cnt_r;
  logic [CONV_W-1:0]     bin_nxt;
  digits_t               bcd_nxt;

  assign job_pop   = (state_r == S_IDLE) && job_valid;
  assign res_valid = (state_r == S_DONE);
  assign res       = '{digits: bcd_r, places: places_r, kind: kind_r};

  // one dabble step per consumed bit
  always_comb begin
    bin_nxt = bin_r;
    bcd_nxt = bcd_r;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (bcd_nxt[d] >= DIGIT_W'(5)) begin
          bcd_nxt[d] = bcd_nxt[d] + DIGIT_W'(3);
        end
      end
      {bcd_nxt, bin_nxt} = {bcd_nxt, bin_nxt} << 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            bin_r    <= CONV_W'(job.amount);
            bcd_r    <= '0;
            places_r <= job.places;
            kind_r   <= job.kind;
            cnt_r    <= STEP_CNT_W'(CONV_STEPS - 1);
            // zero and error words need no digits
            state_r  <= (job.kind == KIND_NUM) ? S_RUN : S_DONE;
          end
        end
        S_RUN: begin
          bin_r <= bin_nxt;
          bcd_r <= bcd_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (res_take) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/fpdf_emit.sv]
// ----------------------------------------------------------------------------
// fpdf_emit: character sequencer
// Walks the digits of one amount: integer part, dot, trimmed fraction, or a
// single zero or NUL character for zero and error words; drives the registered output stage.
// ----------------------------------------------------------------------------
module fpdf_emit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                res_valid,
  input  fpdf_pkg::conv_res_t res,
  output logic                res_take,
  fpdf_out_if.source          out_ch
);
  import fpdf_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SINGLE,
    S_INT,
    S_DOT,
    S_FRAC
  } state_t;

  state_t                 state_r;
  digits_t                dig_r;
  logic [PLACES_W-1:0]    places_r;
  kind_t                  kind_r;
  logic [DIGIT_IDX_W-1:0] idx_r;
  logic [DIGIT_IDX_W-1:0] lo_r;
  logic                   lo_found_r;
  logic                   out_valid_r;
  logic [CHAR_W-1:0]      out_char_r;
  logic                   out_last_r;
  logic                   out_err_r;

  logic                   out_free;
  logic                   emit;
  logic [DIGIT_IDX_W-1:0] hi;
  logic                   hi_found;
  logic [DIGIT_IDX_W-1:0] lo;
  logic                   lo_found;
  logic [CHAR_W-1:0]      dig_char;
  logic                   int_end;
  logic                   frac_end;

  assign out_free        = !out_valid_r || out_ch.ready;
  assign emit            = out_free && (state_r != S_IDLE);
  assign res_take        = (state_r == S_IDLE) && res_valid;
  assign out_ch.valid     = out_valid_r;
  assign out_ch.character = out_char_r;
  assign out_ch.last      = out_last_r;
  assign out_ch.error     = out_err_r;

  assign dig_char = CHAR_ZERO + CHAR_W'(dig_r[idx_r]);
  assign int_end  = (idx_r == DIGIT_IDX_W'(places_r));
  assign frac_end = (idx_r == lo_r);

  // top nonzero integer digit and lowest nonzero fraction digit
  always_comb begin
    hi       = DIGIT_IDX_W'(res.places);
    hi_found = 1'b0;
    lo       = '0;
    lo_found = 1'b0;
    for (int i = 0; i < NUM_DIGITS; i++) begin
      if ((res.digits[i] != '0) && (DIGIT_IDX_W'(i) >= DIGIT_IDX_W'(res.places))) begin
        hi       = DIGIT_IDX_W'(i);
        hi_found = 1'b1;
      end
    end
    for (int i = NUM_DIGITS - 1; i >= 0; i--) begin
      if ((res.digits[i] != '0) && (DIGIT_IDX_W'(i) < DIGIT_IDX_W'(res.places))) begin
        lo       = DIGIT_IDX_W'(i);
        lo_found = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // drop the word once taken unless a new one replaces it
      if (out_ch.ready && !emit) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (res_valid) begin
            dig_r      <= res.digits;
            places_r   <= res.places;
            kind_r     <= res.kind;
            // with no integer digit, start at the zero digit at the places slot
            idx_r      <= hi_found ? hi : DIGIT_IDX_W'(res.places);
            lo_r       <= lo;
            lo_found_r <= lo_found;
            state_r    <= (res.kind == KIND_NUM) ? S_INT : S_SINGLE;
          end
        end
        S_SINGLE: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= (kind_r == KIND_ERR) ? CHAR_NUL : CHAR_ZERO;
            out_last_r  <= 1'b1;
            out_err_r   <= (kind_r == KIND_ERR);
            state_r     <= S_IDLE;
          end
        end
        S_INT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= dig_char;
            out_last_r  <= int_end && !lo_found_r;
            out_err_r   <= 1'b0;
            if (int_end) begin
              state_r <= lo_found_r ? S_DOT : S_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        S_DOT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= CHAR_DOT;
            out_last_r  <= 1'b0;
            out_err_r   <= 1'b0;
            idx_r       <= DIGIT_IDX_W'(places_r) - 1'b1;
            state_r     <= S_FRAC;
          end
        end
        S_FRAC: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_char_r  <= dig_char;
            out_last_r  <= frac_end;
            out_err_r   <= 1'b0;
            if (frac_end) begin
              state_r <= S_IDLE;
            end else begin
              idx_r <= idx_r - 1'b1;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[rtl/fixed_point_decimal_formatter.sv]
// ----------------------------------------------------------------------------
// fixed_point_decimal_formatter: amount to ASCII decimal text
// Front queue, BCD converter and character sequencer in a chain.
//
//   channel  dir  handshake    payload
//   in_ch    in   valid/ready  amount[63:0], decimal_places[4:0]
//   out_ch   out  valid/ready  character[7:0], last, error
//
// Conversion runs in the shift-and-add-3 unit; the sequencer then loads the
// result and emits the characters (up to 21). Converter and sequencer
// overlap, so the converter can work on the next amount while the sequencer
// is still emitting.
// Zero amounts and bad place counts skip the conversion steps.
// Reset is synchronous and clears only control state.
// A stalled output holds its word; the two-entry queue keeps taking input until it is full.
// ----------------------------------------------------------------------------
module fixed_point_decimal_formatter (
  input  logic       clk,
  input  logic       rst_n,
  fpdf_in_if.sink    in_ch,
  fpdf_out_if.source out_ch
);
  import fpdf_pkg::*;

  logic      job_valid;
  job_t      job;
  logic      job_pop;
  logic      res_valid;
  conv_res_t res;
  logic      res_take;

  fpdf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop)
  );

  fpdf_conv u_conv (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .job_pop   (job_pop),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take)
  );

  fpdf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .out_ch    (out_ch)
  );

endmodule
